FILE: src/aecp_pkg.sv
// ============================================================================
// aecp_pkg
// Shared types, constants and AES-128 round functions for the byte-stream
// AES engine (ECB/CBC with PKCS#7 padding).
// ============================================================================
package aecp_pkg;

    // Register indexes of the configuration port.
    localparam logic [2:0] REG_KEY_HIGH   = 3'd0;
    localparam logic [2:0] REG_KEY_LOW    = 3'd1;
    localparam logic [2:0] REG_IV_HIGH    = 3'd2;
    localparam logic [2:0] REG_IV_LOW     = 3'd3;
    localparam logic [2:0] REG_CHAIN_MODE = 3'd4;
    localparam logic [2:0] REG_DIRECTION  = 3'd5;

    // Result status codes.
    localparam logic [1:0] STAT_OK  = 2'd0;
    localparam logic [1:0] STAT_PAD = 2'd1;
    localparam logic [1:0] STAT_LEN = 2'd2;

    // Cipher geometry.
    localparam logic [3:0] ROUND_LAST = 4'd10;
    localparam logic [4:0] BLOCK_LEN  = 5'd16;

    // One block job from the gather stage to the sequencer.
    typedef struct packed {
        logic [127:0] data;   // gathered bytes, byte 0 in bits 127:120
        logic         full;   // a complete block closed with this item
        logic         eom;    // end mark came with this item
        logic [3:0]   cnt;    // leftover byte count after this item
    } job_t;

    // Configuration view handed to the sequencer.
    typedef struct packed {
        logic [63:0] iv_high;
        logic [63:0] iv_low;
        logic [63:0] wr_data;
        logic        iv_hi_wr;
        logic        iv_lo_wr;
        logic        chain_mode;
        logic        direction;
    } cfg_t;

    // Request and response between the sequencer and the cipher core.
    typedef struct packed {
        logic         start;
        logic         inv;
        logic [127:0] data;
    } core_req_t;

    typedef struct packed {
        logic         ready;
        logic         done;
        logic [127:0] data;
    } core_rsp_t;

    // Forward and inverse S-boxes, entry 0 leftmost.
    localparam logic [0:2047] SBOX_BITS = {
        128'h637c777bf26b6fc53001672bfed7ab76,
        128'hca82c97dfa5947f0add4a2af9ca472c0,
        128'hb7fd9326363ff7cc34a5e5f171d83115,
        128'h04c723c31896059a071280e2eb27b275,
        128'h09832c1a1b6e5aa0523bd6b329e32f84,
        128'h53d100ed20fcb15b6acbbe394a4c58cf,
        128'hd0efaafb434d338545f9027f503c9fa8,
        128'h51a3408f929d38f5bcb6da2110fff3d2,
        128'hcd0c13ec5f974417c4a77e3d645d1973,
        128'h60814fdc222a908846eeb814de5e0bdb,
        128'he0323a0a4906245cc2d3ac629195e479,
        128'he7c8376d8dd54ea96c56f4ea657aae08,
        128'hba78252e1ca6b4c6e8dd741f4bbd8b8a,
        128'h703eb5664803f60e613557b986c11d9e,
        128'he1f8981169d98e949b1e87e9ce5528df,
        128'h8ca1890dbfe6426841992d0fb054bb16
    };

    localparam logic [0:2047] INV_SBOX_BITS = {
        128'h52096ad53036a538bf40a39e81f3d7fb,
        128'h7ce339829b2fff87348e4344c4dee9cb,
        128'h547b9432a6c2233dee4c950b42fac34e,
        128'h082ea16628d924b2765ba2496d8bd125,
        128'h72f8f66486689816d4a45ccc5d65b692,
        128'h6c704850fdedb9da5e154657a78d9d84,
        128'h90d8ab008cbcd30af7e45805b8b34506,
        128'hd02c1e8fca3f0f02c1afbd0301138a6b,
        128'h3a9111414f67dcea97f2cfcef0b4e673,
        128'h96ac7422e7ad3585e2f937e81c75df6e,
        128'h47f11a711d29c5896fb7620eaa18be1b,
        128'hfc563e4bc6d279209adbc0fe78cd5af4,
        128'h1fdda8338807c731b11210592780ec5f,
        128'h60517fa919b54a0d2de57a9f93c99cef,
        128'ha0e03b4dae2af5b0c8ebbb3c83539961,
        128'h172b047eba77d626e169146355210c7d
    };

    function automatic logic [7:0] sbox_byte(input logic [7:0] x, input logic inv);
        return inv ? INV_SBOX_BITS[{x, 3'b000} +: 8] : SBOX_BITS[{x, 3'b000} +: 8];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [127:0] sub_bytes(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int k = 0; k < 16; k++)
        begin
            t[127 - 8 * k -: 8] = sbox_byte(s[127 - 8 * k -: 8], inv);
        end
        return t;
    endfunction

    function automatic logic [127:0] shift_rows(input logic [127:0] s, input logic inv);
        logic [127:0] t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                if (inv)
                begin
                    t[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8] = s[127 - 8 * (r + 4 * c) -: 8];
                end
                else
                begin
                    t[127 - 8 * (r + 4 * c) -: 8] = s[127 - 8 * (r + 4 * ((c + r) & 3)) -: 8];
                end
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
            t[119 - 32 * c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
            t[111 - 32 * c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
            t[103 - 32 * c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
        end
        return t;
    endfunction

    // Products by 9, 11, 13 and 14 built from repeated doubling.
    function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] k);
        logic [7:0] x2, x4, x8;
        x2 = xtime(a);
        x4 = xtime(x2);
        x8 = xtime(x4);
        return (k[3] ? x8 : 8'h00) ^ (k[2] ? x4 : 8'h00) ^ (k[1] ? x2 : 8'h00)
             ^ (k[0] ? a : 8'h00);
    endfunction

    function automatic logic [127:0] inv_mix_columns(input logic [127:0] s);
        logic [127:0] t;
        logic [7:0]   a0, a1, a2, a3;
        for (int c = 0; c < 4; c++)
        begin
            a0 = s[127 - 32 * c -: 8];
            a1 = s[119 - 32 * c -: 8];
            a2 = s[111 - 32 * c -: 8];
            a3 = s[103 - 32 * c -: 8];
            t[127 - 32 * c -: 8] = gm(a0, 4'd14) ^ gm(a1, 4'd11) ^ gm(a2, 4'd13) ^ gm(a3, 4'd9);
            t[119 - 32 * c -: 8] = gm(a0, 4'd9) ^ gm(a1, 4'd14) ^ gm(a2, 4'd11) ^ gm(a3, 4'd13);
            t[111 - 32 * c -: 8] = gm(a0, 4'd13) ^ gm(a1, 4'd9) ^ gm(a2, 4'd14) ^ gm(a3, 4'd11);
            t[103 - 32 * c -: 8] = gm(a0, 4'd11) ^ gm(a1, 4'd13) ^ gm(a2, 4'd9) ^ gm(a3, 4'd14);
        end
        return t;
    endfunction

    function automatic logic [7:0] rcon(input logic [3:0] k);
        logic [7:0] r;
        unique case (k)
            4'd1:    r = 8'h01;
            4'd2:    r = 8'h02;
            4'd3:    r = 8'h04;
            4'd4:    r = 8'h08;
            4'd5:    r = 8'h10;
            4'd6:    r = 8'h20;
            4'd7:    r = 8'h40;
            4'd8:    r = 8'h80;
            4'd9:    r = 8'h1b;
            4'd10:   r = 8'h36;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // One step of the key schedule: round key k from round key k-1.
    function automatic logic [127:0] key_step(input logic [127:0] prev, input logic [3:0] k);
        logic [31:0] rot, t, w0, w1, w2, w3;
        rot = {prev[23:0], prev[31:24]};
        t = {sbox_byte(rot[31:24], 1'b0), sbox_byte(rot[23:16], 1'b0),
             sbox_byte(rot[15:8], 1'b0), sbox_byte(rot[7:0], 1'b0)} ^ {rcon(k), 24'h000000};
        w0 = prev[127:96] ^ t;
        w1 = prev[95:64] ^ w0;
        w2 = prev[63:32] ^ w1;
        w3 = prev[31:0] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

FILE: src/aecp_if.sv
// ============================================================================
// aecp_if
// Valid/ready channels carrying message bytes in and result bytes out.
// ============================================================================
interface aecp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_valid,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input end_of_message, output ready);
endinterface

interface aecp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output out_byte, output out_valid,
                    output last, output status, input ready);
    modport sink   (input valid, input out_byte, input out_valid,
                    input last, input status, output ready);
endinterface

FILE: src/aecp_front.sv
// ============================================================================
// aecp_front
// Gathers message bytes into 16-byte blocks and posts a job whenever a
// block fills or the end mark arrives.
// ============================================================================
module aecp_front (
    input  logic          clk,
    input  logic          rst_n,
    aecp_in_if.sink       din,
    input  logic          q_full,
    output logic          q_push,
    output aecp_pkg::job_t q_job
);
    import aecp_pkg::*;

    logic [127:0] gbuf_reg;
    logic [127:0] gbuf_next;
    logic [3:0]   gcnt_reg;
    logic [3:0]   gcnt_next;
    logic         accept;
    logic         closes;

    assign din.ready = !q_full;
    assign accept    = din.valid && din.ready;
    assign closes    = din.byte_valid && (gcnt_reg == 4'd15);

    // Drop the new byte into its slot of the gather buffer.
    always_comb
    begin
        for (int k = 0; k < 16; k++)
        begin
            gbuf_next[127 - 8 * k -: 8] = (din.byte_valid && (gcnt_reg == 4'(k)))
                                         ? din.data_byte : gbuf_reg[127 - 8 * k -: 8];
        end
    end

    // Job for the sequencer; the count wraps to zero on a full block.
    always_comb
    begin
        q_job.data = gbuf_next;
        q_job.full = closes;
        q_job.eom  = din.end_of_message;
        q_job.cnt  = din.byte_valid ? gcnt_reg + 4'd1 : gcnt_reg;
        q_push     = accept && (closes || din.end_of_message);
    end

    always_comb
    begin
        gcnt_next = gcnt_reg;
        if (accept)
        begin
            gcnt_next = din.end_of_message ? 4'd0 : q_job.cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gcnt_reg <= 4'd0;
        end
        else
        begin
            gcnt_reg <= gcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            gbuf_reg <= gbuf_next;
        end
    end

endmodule

FILE: src/aecp_queue.sv
// ============================================================================
// aecp_queue
// Short job queue that lets the gather stage and the sequencer stall apart.
// ============================================================================
module aecp_queue #(
    parameter int DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  aecp_pkg::job_t push_job,
    input  logic           pop,
    output aecp_pkg::job_t head,
    output logic           full,
    output logic           empty
);
    import aecp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: src/aecp_core.sv
// ============================================================================
// aecp_core
// Iterative AES-128 cipher, one round per cycle, with a round-key store
// that is refilled after reset and after every key write.
// ============================================================================
module aecp_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [63:0]         key_high,
    input  logic [63:0]         key_low,
    input  logic                key_wr,
    input  aecp_pkg::core_req_t req,
    output aecp_pkg::core_rsp_t rsp
);
    import aecp_pkg::*;

    logic [127:0] rk_reg [11];
    logic [127:0] kx_prev_reg;
    logic [127:0] kx_step;
    logic [3:0]   kx_cnt_reg;
    logic         kx_busy_reg;

    logic [127:0] state_reg;
    logic [3:0]   round_reg;
    logic         busy_reg;
    logic         fin_reg;
    logic         inv_reg;

    logic [127:0] rk_cur;
    logic [127:0] enc_sr;
    logic [127:0] enc_out;
    logic [127:0] dec_ark;
    logic [127:0] dec_out;
    logic         last_round;
    logic         go;

    assign kx_step = key_step(kx_prev_reg, kx_cnt_reg);
    assign go      = req.start && rsp.ready;

    // Key schedule sweep: entry 0 is the key, entries 1..10 follow.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kx_busy_reg <= 1'b1;
            kx_cnt_reg  <= 4'd0;
        end
        else if (key_wr)
        begin
            kx_busy_reg <= 1'b1;
            kx_cnt_reg  <= 4'd0;
        end
        else if (kx_busy_reg)
        begin
            kx_cnt_reg <= kx_cnt_reg + 4'd1;
            if (kx_cnt_reg == ROUND_LAST)
            begin
                kx_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (kx_busy_reg && !key_wr)
        begin
            if (kx_cnt_reg == 4'd0)
            begin
                rk_reg[0]   <= {key_high, key_low};
                kx_prev_reg <= {key_high, key_low};
            end
            else
            begin
                rk_reg[kx_cnt_reg] <= kx_step;
                kx_prev_reg        <= kx_step;
            end
        end
    end

    // One round of either direction.
    always_comb
    begin
        rk_cur     = rk_reg[round_reg];
        enc_sr     = shift_rows(sub_bytes(state_reg, 1'b0), 1'b0);
        enc_out    = ((round_reg == ROUND_LAST) ? enc_sr : mix_columns(enc_sr)) ^ rk_cur;
        dec_ark    = sub_bytes(shift_rows(state_reg, 1'b1), 1'b1) ^ rk_cur;
        dec_out    = (round_reg == 4'd0) ? dec_ark : inv_mix_columns(dec_ark);
        last_round = inv_reg ? (round_reg == 4'd0) : (round_reg == ROUND_LAST);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
        end
        else if (go)
        begin
            busy_reg <= 1'b1;
            fin_reg  <= 1'b0;
        end
        else if (busy_reg && last_round)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b1;
        end
    end

    // Initial key addition on start, then the rounds.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            inv_reg   <= req.inv;
            state_reg <= req.data ^ (req.inv ? rk_reg[ROUND_LAST] : rk_reg[0]);
            round_reg <= req.inv ? ROUND_LAST - 4'd1 : 4'd1;
        end
        else if (busy_reg)
        begin
            state_reg <= inv_reg ? dec_out : enc_out;
            round_reg <= inv_reg ? round_reg - 4'd1 : round_reg + 4'd1;
        end
    end

    assign rsp.ready = !busy_reg && !kx_busy_reg;
    assign rsp.done  = fin_reg && !busy_reg;
    assign rsp.data  = state_reg;

endmodule

FILE: src/aecp_back.sv
// ============================================================================
// aecp_back
// Job sequencer: chaining, padding, hold-back and pad check around the
// cipher core, plus the byte serializer that drives the result channel.
// ============================================================================
module aecp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  aecp_pkg::cfg_t      cfg,
    input  aecp_pkg::job_t      q_head,
    input  logic                q_empty,
    output logic                q_pop,
    output aecp_pkg::core_req_t core_req,
    input  aecp_pkg::core_rsp_t core_rsp,
    aecp_out_if.source          dout
);
    import aecp_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_BLK_START = 3'd1;
    localparam logic [2:0] S_BLK_WAIT  = 3'd2;
    localparam logic [2:0] S_END       = 3'd3;
    localparam logic [2:0] S_END_WAIT  = 3'd4;

    typedef struct packed {
        logic [127:0] data;
        logic [4:0]   nbytes;
        logic         last;
        logic         stat_only;
        logic [1:0]   status;
    } emit_t;

    logic [2:0]   state_reg, state_next;
    job_t         job_reg, job_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] held_reg, held_next;
    logic         held_valid_reg, held_valid_next;
    logic [127:0] ct_reg, ct_next;

    logic         e_busy_reg;
    emit_t        e_reg;
    emit_t        desc;
    logic         emit_load;
    logic         emit_done_now;
    logic         emit_free;

    logic [127:0] iv;
    logic [127:0] chain_x;
    logic [127:0] pad_blk;
    logic [7:0]   pad_val;
    logic [7:0]   p;
    logic         pad_bad;
    emit_t        end_desc;

    assign iv      = {cfg.iv_high, cfg.iv_low};
    assign chain_x = cfg.chain_mode ? chain_reg : '0;

    // Serializer frees up in the same cycle its final item is taken.
    assign emit_done_now = e_busy_reg && dout.ready
                           && (e_reg.stat_only || (e_reg.nbytes == 5'd1));
    assign emit_free     = !e_busy_reg || emit_done_now;

    // Padded final block for encryption.
    always_comb
    begin
        pad_val = 8'(BLOCK_LEN - {1'b0, job_reg.cnt});
        for (int k = 0; k < 16; k++)
        begin
            pad_blk[127 - 8 * k -: 8] = (4'(k) < job_reg.cnt)
                                       ? job_reg.data[127 - 8 * k -: 8] : pad_val;
        end
    end

    // Pad check on the held block and the final result it leads to.
    always_comb
    begin
        p       = held_reg[7:0];
        pad_bad = (p == 8'd0) || (p > 8'd16);
        for (int i = 0; i < 16; i++)
        begin
            if ((8'(i) < p) && (held_reg[8 * i +: 8] != p))
            begin
                pad_bad = 1'b1;
            end
        end
        end_desc           = '0;
        end_desc.data      = held_reg;
        end_desc.last      = 1'b1;
        end_desc.stat_only = 1'b1;
        end_desc.status    = STAT_OK;
        if ((job_reg.cnt != 4'd0) || !held_valid_reg)
        begin
            end_desc.status = STAT_LEN;
        end
        else if (pad_bad)
        begin
            end_desc.status = STAT_PAD;
        end
        else if (p != 8'd16)
        begin
            end_desc.stat_only = 1'b0;
            end_desc.nbytes    = BLOCK_LEN - p[4:0];
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next      = state_reg;
        job_next        = job_reg;
        chain_next      = chain_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        ct_next         = ct_reg;
        q_pop           = 1'b0;
        core_req.start  = 1'b0;
        core_req.inv    = cfg.direction;
        core_req.data   = job_reg.data;
        emit_load       = 1'b0;
        desc            = '0;
        desc.data       = core_rsp.data;
        desc.nbytes     = BLOCK_LEN;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    job_next   = q_head;
                    state_next = q_head.full ? S_BLK_START : S_END;
                end
            end

            S_BLK_START:
            begin
                core_req.data = cfg.direction ? job_reg.data : job_reg.data ^ chain_x;
                if (core_rsp.ready)
                begin
                    core_req.start = 1'b1;
                    ct_next        = job_reg.data;
                    state_next     = S_BLK_WAIT;
                end
            end

            S_BLK_WAIT:
            begin
                if (core_rsp.done && !cfg.direction && emit_free)
                begin
                    emit_load = 1'b1;
                    if (cfg.chain_mode)
                    begin
                        chain_next = core_rsp.data;
                    end
                    state_next = job_reg.eom ? S_END : S_IDLE;
                end
                else if (core_rsp.done && cfg.direction && (emit_free || !held_valid_reg))
                begin
                    emit_load       = held_valid_reg;
                    desc.data       = held_reg;
                    held_next       = core_rsp.data ^ chain_x;
                    held_valid_next = 1'b1;
                    if (cfg.chain_mode)
                    begin
                        chain_next = ct_reg;
                    end
                    state_next = job_reg.eom ? S_END : S_IDLE;
                end
            end

            S_END:
            begin
                core_req.data = pad_blk ^ chain_x;
                core_req.inv  = 1'b0;
                if (!cfg.direction)
                begin
                    if (core_rsp.ready)
                    begin
                        core_req.start = 1'b1;
                        state_next     = S_END_WAIT;
                    end
                end
                else if (emit_free)
                begin
                    emit_load       = 1'b1;
                    desc            = end_desc;
                    held_valid_next = 1'b0;
                    chain_next      = iv;
                    state_next      = S_IDLE;
                end
            end

            S_END_WAIT:
            begin
                if (core_rsp.done && emit_free)
                begin
                    emit_load       = 1'b1;
                    desc.last       = 1'b1;
                    held_valid_next = 1'b0;
                    chain_next      = iv;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state and chain value; IV writes reload the chain at once.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_valid_reg <= 1'b0;
            chain_reg      <= '0;
            e_busy_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_valid_reg <= held_valid_next;
            if (cfg.iv_hi_wr)
            begin
                chain_reg <= {cfg.wr_data, cfg.iv_low};
            end
            else if (cfg.iv_lo_wr)
            begin
                chain_reg <= {chain_reg[127:64], cfg.wr_data};
            end
            else
            begin
                chain_reg <= chain_next;
            end
            if (emit_load)
            begin
                e_busy_reg <= 1'b1;
            end
            else if (emit_done_now)
            begin
                e_busy_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the serializer shift.
    always_ff @(posedge clk)
    begin
        job_reg  <= job_next;
        held_reg <= held_next;
        ct_reg   <= ct_next;
        if (emit_load)
        begin
            e_reg <= desc;
        end
        else if (e_busy_reg && dout.ready)
        begin
            e_reg.data   <= {e_reg.data[119:0], 8'h00};
            e_reg.nbytes <= e_reg.nbytes - 5'd1;
        end
    end

    // Result channel.
    assign dout.valid     = e_busy_reg;
    assign dout.out_byte  = e_reg.stat_only ? 8'h00 : e_reg.data[127:120];
    assign dout.out_valid = !e_reg.stat_only;
    assign dout.last      = e_reg.stat_only || (e_reg.last && (e_reg.nbytes == 5'd1));
    assign dout.status    = e_reg.stat_only ? e_reg.status : STAT_OK;

endmodule

FILE: src/aes_ecb_cbc_pkcs7_engine.sv
// ============================================================================
// aes_ecb_cbc_pkcs7_engine
// AES-128 byte-stream engine, ECB or CBC, with PKCS#7 pad and strip.
// ============================================================================
// Usage:
//   din carries one message byte per item (byte_valid) and an end mark
//   (end_of_message); dout returns result bytes, with last on the final
//   item of a message and a status on a byte-less final item.
//   Registers are written through wr_en / wr_index / wr_data while idle.
// Throughput: one input item per cycle while din.ready is high; results
//   leave at one byte per cycle while dout.ready is high. The round unit
//   works on one 16-byte block while the serializer sends the one before,
//   so the serializer sets the sustained rate of one byte/cycle.
// Result path: a block is queued, run through the round unit (a load step
//   and ten rounds) and serialized; decryption holds each block back
//   until the next block or the end mark arrives.
// Reset: control state and configuration clear and the round keys are
//   rebuilt; every key write starts the same rebuild, during which blocks
//   wait in the job queue.
// Stalls: a stalled receiver fills the serializer, then the job queue,
//   and only then drops din.ready.
// ============================================================================
module aes_ecb_cbc_pkcs7_engine #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    aecp_in_if.sink     din,
    aecp_out_if.source  dout,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [63:0] wr_data
);
    import aecp_pkg::*;

    logic [63:0] key_high_reg;
    logic [63:0] key_low_reg;
    logic [63:0] iv_high_reg;
    logic [63:0] iv_low_reg;
    logic        chain_mode_reg;
    logic        direction_reg;

    cfg_t        cfg;
    job_t        front_job;
    job_t        q_head;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    core_req_t   core_req;
    core_rsp_t   core_rsp;
    logic        key_wr;

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg   <= '0;
            key_low_reg    <= '0;
            iv_high_reg    <= '0;
            iv_low_reg     <= '0;
            chain_mode_reg <= 1'b0;
            direction_reg  <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_KEY_HIGH:   key_high_reg   <= wr_data;
                REG_KEY_LOW:    key_low_reg    <= wr_data;
                REG_IV_HIGH:    iv_high_reg    <= wr_data;
                REG_IV_LOW:     iv_low_reg     <= wr_data;
                REG_CHAIN_MODE: chain_mode_reg <= wr_data[0];
                REG_DIRECTION:  direction_reg  <= wr_data[0];
                default:        ;
            endcase
        end
    end

    assign key_wr = wr_en && ((wr_index == REG_KEY_HIGH) || (wr_index == REG_KEY_LOW));

    always_comb
    begin
        cfg.iv_high    = iv_high_reg;
        cfg.iv_low     = iv_low_reg;
        cfg.wr_data    = wr_data;
        cfg.iv_hi_wr   = wr_en && (wr_index == REG_IV_HIGH);
        cfg.iv_lo_wr   = wr_en && (wr_index == REG_IV_LOW);
        cfg.chain_mode = chain_mode_reg;
        cfg.direction  = direction_reg;
    end

    aecp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .din    (din),
        .q_full (q_full),
        .q_push (q_push),
        .q_job  (front_job)
    );

    aecp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (front_job),
        .pop      (q_pop),
        .head     (q_head),
        .full     (q_full),
        .empty    (q_empty)
    );

    aecp_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .key_high (key_high_reg),
        .key_low  (key_low_reg),
        .key_wr   (key_wr),
        .req      (core_req),
        .rsp      (core_rsp)
    );

    aecp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_head   (q_head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .core_req (core_req),
        .core_rsp (core_rsp),
        .dout     (dout)
    );

endmodule

FILE: src/aecp_checker.sv
// ============================================================================
// aecp_checker
// Port-level checks on the result channel of the AES byte-stream engine.
// ============================================================================
module aecp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       o_vld,
    input logic       o_rdy,
    input logic [7:0] o_byte,
    input logic       o_has,
    input logic       o_last,
    input logic [1:0] o_status
);
    import aecp_pkg::*;

    // An error status only rides on a final item that carries no byte.
    property p_status_final;
        @(posedge clk) disable iff (!rst_n)
        (o_vld && (o_status != STAT_OK)) |-> (o_last && !o_has);
    endproperty
    a_status_final: assert property (p_status_final)
        else $error("error status on a non-final or byte-carrying item");

    // An item without a byte is always the final item of its message.
    property p_empty_is_last;
        @(posedge clk) disable iff (!rst_n)
        (o_vld && !o_has) |-> (o_last && (o_byte == 8'h00));
    endproperty
    a_empty_is_last: assert property (p_empty_is_last)
        else $error("byte-less item is not a final item");

    // Unused status code never appears.
    property p_status_code;
        @(posedge clk) disable iff (!rst_n)
        o_vld |-> ((o_status == STAT_OK) || (o_status == STAT_PAD)
                   || (o_status == STAT_LEN));
    endproperty
    a_status_code: assert property (p_status_code)
        else $error("undefined status code");

    // A stalled result holds still.
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        (o_vld && !o_rdy) |=> (o_vld && $stable(o_byte) && $stable(o_has)
                               && $stable(o_last) && $stable(o_status));
    endproperty
    a_hold: assert property (p_hold)
        else $error("stalled result changed or was withdrawn");

endmodule

bind aes_ecb_cbc_pkcs7_engine aecp_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .o_vld    (dout.valid),
    .o_rdy    (dout.ready),
    .o_byte   (dout.out_byte),
    .o_has    (dout.out_valid),
    .o_last   (dout.last),
    .o_status (dout.status)
);

FILE: dv/aes_ecb_cbc_pkcs7_engine_test.sv
`timescale 1ns / 100ps
// ============================================================================
// aes_ecb_cbc_pkcs7_engine_test
// Self-checking bench for the AES-128 byte-stream engine. Messages are sent
// through the input channel and each result item is checked against an
// in-bench AES-128 ECB/CBC predictor with PKCS#7 pad and strip. The bench
// steps through several key, IV, mode and direction settings and varies
// idling on both channels.
// ============================================================================
module aes_ecb_cbc_pkcs7_engine_test;
    import aecp_pkg::*;

    // Index values the engine does not decode.
    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam int SETTLE_CYCLES = 60;
    localparam int HOLD_CYCLES   = 400;

    typedef logic [15:0][7:0] blk_t;
    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        logic       last;
        logic [1:0] status;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [63:0] wr_data;

    aecp_in_if  din ();
    aecp_out_if dout ();

    aes_ecb_cbc_pkcs7_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .din      (din.sink),
        .dout     (dout.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    // Clock.
    always #4 clk = ~clk;

    // Cipher tables and predictor state.
    logic [7:0]  fwd_sbox [256];
    logic [7:0]  inv_sbox [256];
    logic [31:0] sched [44];
    logic [63:0] key_hi, key_lo, iv_hi, iv_lo;
    logic        cbc_on, decrypt_on;
    logic [7:0]  gather [16];
    int          gather_cnt;
    blk_t        chain, held;
    logic        held_ok;

    msg_item_t pending_items[$];
    result_t   expected_results[$];

    int idle_in_pct, stall_out_pct;
    int failures, items_in, results_out, messages, error_results;
    logic hold_req, hold_done;
    int   hold_left;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[0])
                p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
            b = b >> 1;
        end
        return p;
    endfunction

    function automatic void build_sboxes();
        logic [7:0] v, s;
        for (int x = 0; x < 256; x++)
        begin
            v = 8'h00;
            if (x != 0)
            begin
                for (int y = 1; y < 256; y++)
                begin
                    if (gf_mul(x[7:0], y[7:0]) == 8'h01)
                    begin
                        v = y[7:0];
                        break;
                    end
                end
            end
            s = v ^ {v[6:0], v[7]} ^ {v[5:0], v[7:6]} ^ {v[4:0], v[7:5]}
                ^ {v[3:0], v[7:4]} ^ 8'h63;
            fwd_sbox[x] = s;
            inv_sbox[s] = x[7:0];
        end
    endfunction

    // Key schedule from the current key registers.
    function automatic void expand_schedule();
        logic [31:0] t;
        logic [7:0]  rc;
        sched[0] = key_hi[63:32];
        sched[1] = key_hi[31:0];
        sched[2] = key_lo[63:32];
        sched[3] = key_lo[31:0];
        rc = 8'h01;
        for (int i = 4; i < 44; i++)
        begin
            t = sched[i - 1];
            if ((i & 3) == 0)
            begin
                t = {t[23:0], t[31:24]};
                t = {fwd_sbox[t[31:24]], fwd_sbox[t[23:16]], fwd_sbox[t[15:8]],
                     fwd_sbox[t[7:0]]} ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            sched[i] = sched[i - 4] ^ t;
        end
    endfunction

    function automatic blk_t add_round(input blk_t s, input int r);
        for (int c = 0; c < 4; c++)
            for (int j = 0; j < 4; j++)
                s[4 * c + j] ^= sched[4 * r + c][31 - 8 * j -: 8];
        return s;
    endfunction

    function automatic blk_t shuffle_rows(input blk_t s, input logic inverse);
        blk_t t;
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                if (inverse)
                    t[r + 4 * ((c + r) & 3)] = s[r + 4 * c];
                else
                    t[r + 4 * c] = s[r + 4 * ((c + r) & 3)];
        return t;
    endfunction

    function automatic blk_t mix_cols(input blk_t s, input logic inverse);
        logic [7:0] m [4];
        logic [7:0] a [4];
        blk_t t;
        if (inverse)
            m = '{8'd14, 8'd11, 8'd13, 8'd9};
        else
            m = '{8'd2, 8'd3, 8'd1, 8'd1};
        for (int c = 0; c < 4; c++)
        begin
            for (int j = 0; j < 4; j++)
                a[j] = s[4 * c + j];
            for (int row = 0; row < 4; row++)
            begin
                t[4 * c + row] = 8'h00;
                for (int j = 0; j < 4; j++)
                    t[4 * c + row] ^= gf_mul(a[j], m[(j - row + 4) & 3]);
            end
        end
        return t;
    endfunction

    function automatic blk_t aes_forward(input blk_t s);
        expand_schedule();
        s = add_round(s, 0);
        for (int r = 1; r <= 10; r++)
        begin
            for (int i = 0; i < 16; i++)
                s[i] = fwd_sbox[s[i]];
            s = shuffle_rows(s, 1'b0);
            if (r < 10)
                s = mix_cols(s, 1'b0);
            s = add_round(s, r);
        end
        return s;
    endfunction

    function automatic blk_t aes_inverse(input blk_t s);
        expand_schedule();
        s = add_round(s, 10);
        for (int r = 9; r >= 0; r--)
        begin
            s = shuffle_rows(s, 1'b1);
            for (int i = 0; i < 16; i++)
                s[i] = inv_sbox[s[i]];
            s = add_round(s, r);
            if (r > 0)
                s = mix_cols(s, 1'b1);
        end
        return s;
    endfunction

    function automatic blk_t iv_block();
        return {iv_lo[7:0], iv_lo[15:8], iv_lo[23:16], iv_lo[31:24], iv_lo[39:32],
                iv_lo[47:40], iv_lo[55:48], iv_lo[63:56], iv_hi[7:0], iv_hi[15:8],
                iv_hi[23:16], iv_hi[31:24], iv_hi[39:32], iv_hi[47:40], iv_hi[55:48],
                iv_hi[63:56]};
    endfunction

    function automatic void add_result(input logic [7:0] b, input logic ov, input logic lst,
                                       input logic [1:0] st);
        expected_results.push_back('{b, ov, lst, st});
    endfunction

    function automatic blk_t encrypt_chained(input blk_t b);
        if (cbc_on)
            b ^= chain;
        b = aes_forward(b);
        if (cbc_on)
            chain = b;
        return b;
    endfunction

    // Works out the results of one accepted input item.
    function automatic void predict_item(input msg_item_t it);
        blk_t b, ct;
        int   p;
        logic good;
        if (it.byte_valid)
        begin
            gather[gather_cnt] = it.data_byte;
            gather_cnt++;
            if (gather_cnt == 16)
            begin
                gather_cnt = 0;
                for (int i = 0; i < 16; i++)
                    b[i] = gather[i];
                if (!decrypt_on)
                begin
                    b = encrypt_chained(b);
                    for (int i = 0; i < 16; i++)
                        add_result(b[i], 1'b1, 1'b0, STAT_OK);
                end
                else
                begin
                    ct = b;
                    b = aes_inverse(b);
                    if (cbc_on)
                    begin
                        b ^= chain;
                        chain = ct;
                    end
                    if (held_ok)
                        for (int i = 0; i < 16; i++)
                            add_result(held[i], 1'b1, 1'b0, STAT_OK);
                    held = b;
                    held_ok = 1'b1;
                end
            end
        end
        if (it.end_of_message)
        begin
            if (!decrypt_on)
            begin
                for (int i = 0; i < 16; i++)
                    b[i] = (i < gather_cnt) ? gather[i] : 8'(16 - gather_cnt);
                b = encrypt_chained(b);
                for (int i = 0; i < 16; i++)
                    add_result(b[i], 1'b1, i == 15, STAT_OK);
            end
            else if (gather_cnt != 0 || !held_ok)
            begin
                add_result(8'h00, 1'b0, 1'b1, STAT_LEN);
            end
            else
            begin
                p = held[15];
                good = p >= 1 && p <= 16;
                for (int i = 0; good && i < p; i++)
                    if (held[15 - i] != p)
                        good = 1'b0;
                if (!good)
                    add_result(8'h00, 1'b0, 1'b1, STAT_PAD);
                else if (p == 16)
                    add_result(8'h00, 1'b0, 1'b1, STAT_OK);
                else
                    for (int i = 0; i < 16 - p; i++)
                        add_result(held[i], 1'b1, i == 15 - p, STAT_OK);
            end
            gather_cnt = 0;
            held_ok = 1'b0;
            chain = iv_block();
        end
    endfunction

    // Enciphers whole blocks without padding, for building decrypt input.
    function automatic byte_q_t encipher_raw(input byte_q_t raw);
        byte_q_t ct;
        blk_t    b, cv;
        cv = iv_block();
        for (int k = 0; k + 16 <= raw.size(); k += 16)
        begin
            for (int i = 0; i < 16; i++)
                b[i] = raw[k + i] ^ (cbc_on ? cv[i] : 8'h00);
            b = aes_forward(b);
            cv = b;
            for (int i = 0; i < 16; i++)
                ct.push_back(b[i]);
        end
        return ct;
    endfunction

    function automatic byte_q_t random_bytes(input int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    // Queues one message, with an occasional empty item in between.
    function automatic void queue_message(input byte_q_t bytes, input logic split_end);
        for (int i = 0; i < bytes.size(); i++)
        begin
            if ($urandom_range(9) == 0)
                pending_items.push_back('{8'($urandom), 1'b0, 1'b0});
            pending_items.push_back('{bytes[i], 1'b1,
                                      !split_end && i == bytes.size() - 1});
        end
        if (split_end || bytes.size() == 0)
            pending_items.push_back('{8'($urandom), 1'b0, 1'b1});
        messages++;
    endfunction

    // Builds a decrypt message of the given kind.
    function automatic void queue_decrypt(input int kind);
        byte_q_t raw;
        int      n, p;
        case (kind)
            0, 1, 2, 3, 4, 5, 6:
            begin
                raw = random_bytes($urandom_range(0, 36));
                p = 16 - (raw.size() % 16);
                for (int i = 0; i < p; i++)
                    raw.push_back(8'(p));
                queue_message(encipher_raw(raw), $urandom_range(1));
            end
            7:
            begin
                // Last plaintext byte is a pad of zero or above 16, or a pad with a mismatched byte before it.
                raw = random_bytes(16 * $urandom_range(1, 2));
                n = raw.size();
                case ($urandom_range(2))
                    0: raw[n - 1] = 8'h00;
                    1: raw[n - 1] = 8'($urandom_range(17, 255));
                    default:
                    begin
                        p = $urandom_range(2, 16);
                        for (int i = 1; i <= p; i++)
                            raw[n - i] = 8'(p);
                        raw[n - $urandom_range(2, p)] ^= 8'($urandom_range(1, 255));
                    end
                endcase
                queue_message(encipher_raw(raw), $urandom_range(1));
            end
            8:
            begin
                n = $urandom_range(0, 40);
                if (n % 16 == 0 && n != 0)
                    n++;
                queue_message(random_bytes(n), $urandom_range(1));
            end
            default:
                queue_message(random_bytes(16 * $urandom_range(1, 2)), $urandom_range(1));
        endcase
    endfunction

    // Input driver: takes items from the pending queue, predicts on acceptance.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (din.valid && din.ready)
            begin
                predict_item('{din.data_byte, din.byte_valid, din.end_of_message});
                items_in++;
            end
            if (!din.valid || din.ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_in_pct)
                begin
                    msg_item_t it;
                    it = pending_items.pop_front();
                    din.valid          <= 1'b1;
                    din.data_byte      <= it.data_byte;
                    din.byte_valid     <= it.byte_valid;
                    din.end_of_message <= it.end_of_message;
                end
                else
                begin
                    din.valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here once requested.
    always @(posedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Output monitor: checks each accepted result item against the oldest one expected.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (dout.valid && dout.ready)
            begin
                result_t want;
                results_out++;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item: out_byte %h last %b status %0d",
                           dout.out_byte, dout.last, dout.status);
                    failures++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (dout.status != STAT_OK)
                        error_results++;
                    if (dout.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, dout.out_byte);
                        failures++;
                    end
                    if (dout.out_valid !== want.out_valid)
                    begin
                        $error("out_valid: expected %b, got %b", want.out_valid, dout.out_valid);
                        failures++;
                    end
                    if (dout.last !== want.last)
                    begin
                        $error("last: expected %b, got %b", want.last, dout.last);
                        failures++;
                    end
                    if (dout.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, dout.status);
                        failures++;
                    end
                end
            end
            dout.ready <= (hold_left > 1) ? 1'b0 : ($urandom_range(99) >= stall_out_pct);
        end
    end

    // Writes one register and mirrors it into the predictor.
    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            REG_KEY_HIGH:   key_hi = val;
            REG_KEY_LOW:    key_lo = val;
            REG_IV_HIGH:    iv_hi = val;
            REG_IV_LOW:     iv_lo = val;
            REG_CHAIN_MODE: cbc_on = val[0];
            REG_DIRECTION:  decrypt_on = val[0];
            default:        ;
        endcase
        if (idx == REG_IV_HIGH || idx == REG_IV_LOW)
            chain = iv_block();
    endtask

    task automatic configure(input logic [63:0] kh, input logic [63:0] kl,
                             input logic [63:0] ih, input logic [63:0] il,
                             input logic cbc, input logic dec);
        write_reg(REG_KEY_HIGH, kh);
        write_reg(REG_KEY_LOW, kl);
        write_reg(REG_IV_HIGH, ih);
        write_reg(REG_IV_LOW, il);
        write_reg(REG_CHAIN_MODE, {63'h0, cbc});
        write_reg(REG_DIRECTION, {63'h0, dec});
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    // Waits until every item is sent and every result has come back.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_items.size() > 0 || din.valid || expected_results.size() > 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        byte_q_t msg;
        int      phase;
        clk = 1'b0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = REG_KEY_HIGH;
        wr_data = 64'h0;
        din.valid = 1'b0;
        din.data_byte = 8'h00;
        din.byte_valid = 1'b0;
        din.end_of_message = 1'b0;
        dout.ready = 1'b0;
        failures = 0; items_in = 0; results_out = 0; messages = 0; error_results = 0;
        hold_req = 1'b0; hold_done = 1'b0; hold_left = 0;
        idle_in_pct = 0; stall_out_pct = 0;
        key_hi = 64'h0; key_lo = 64'h0; iv_hi = 64'h0; iv_lo = 64'h0;
        cbc_on = 1'b0; decrypt_on = 1'b0;
        gather_cnt = 0; held_ok = 1'b0; held = '0;
        build_sboxes();
        chain = iv_block();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (20) @(posedge clk);

        // Directed: ECB encrypt with an all-zero key, undecoded indexes ignored.
        write_reg(REG_SPARE_A, {64{1'b1}});
        write_reg(REG_SPARE_B, {64{1'b1}});
        configure(64'h0, 64'h0, 64'h0, 64'h0, 1'b0, 1'b0);
        pending_items.push_back('{8'hff, 1'b0, 1'b0});
        queue_message(msg, 1'b1);
        msg = '{8'h00};
        queue_message(msg, 1'b0);
        msg = random_bytes(15);
        msg[0] = 8'hff;
        queue_message(msg, 1'b1);
        drain();

        // Directed: CBC decrypt, one of each error and the whole pad block.
        configure({64{1'b1}}, {64{1'b1}}, {64{1'b1}}, {64{1'b1}}, 1'b1, 1'b1);
        msg = {};
        queue_message(msg, 1'b1);
        for (int k = 5; k < 10; k++)
            queue_decrypt(k);
        msg = {};
        for (int i = 0; i < 16; i++)
            msg.push_back(8'h10);
        queue_message(encipher_raw(msg), 1'b0);
        drain();

        // Random phases across settings and idling patterns.
        phase = 0;
        while (phase < 4 || items_in < 410)
        begin
            case (phase % 4)
                0: begin idle_in_pct = 0;  stall_out_pct = 0;  end
                1: begin idle_in_pct = 78; stall_out_pct = 0;  end
                2: begin idle_in_pct = 0;  stall_out_pct = 78; end
                default: begin idle_in_pct = 9; stall_out_pct = 9; end
            endcase
            if (phase == 0)
                configure(64'h0, 64'h0, {64{1'b1}}, 64'h0, 1'b1, 1'b0);
            else
                configure({$urandom, $urandom}, {$urandom, $urandom},
                          {$urandom, $urandom}, {$urandom, $urandom},
                          phase[1], phase[0] ^ phase[2]);
            if (phase == 0)
            begin
                // The receiver holds off while the sender keeps offering bytes.
                stall_out_pct = 0;
                idle_in_pct = 0;
                hold_req = 1'b1;
                queue_message(random_bytes(96), 1'b0);
            end
            if (decrypt_on)
                queue_decrypt($urandom_range(9));
            else
                queue_message(random_bytes($urandom_range(0, 40)), $urandom_range(1));
            drain();
            phase++;
        end

        if (expected_results.size() != 0)
        begin
            $error("%0d expected result items never arrived", expected_results.size());
            failures++;
        end
        $display("Sent %0d items in %0d messages over %0d settings phases.",
                 items_in, messages, phase + 2);
        $display("Checked %0d result items, %0d of them error results.",
                 results_out, error_results);
        if (failures == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Run limit.
    initial
    begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/aecp_pkg.sv
src/aecp_if.sv
src/aecp_front.sv
src/aecp_queue.sv
src/aecp_core.sv
src/aecp_back.sv
src/aes_ecb_cbc_pkcs7_engine.sv
src/aecp_checker.sv
dv/aes_ecb_cbc_pkcs7_engine_test.sv
